// ===== hw/rtl/lse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

  // Decode phases, one-hot
  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_PASS    = 7'b0000010,
    PH_EXT_LEN = 7'b0000100,
    PH_EXT     = 7'b0001000,
    PH_SIZE    = 7'b0010000,
    PH_DATA    = 7'b0100000,
    PH_STOP    = 7'b1000000
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_EXT    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_OK     = 3'd2,
    KIND_REJECT = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_t;

  // Register indexes on the write port
  localparam logic [1:0] REG_PASS_CHARS  = 2'd0;
  localparam logic [1:0] REG_PASS_LEN    = 2'd1;
  localparam logic [1:0] REG_HEADER_SKIP = 2'd2;

  localparam logic [3:0] PASS_LEN_RESET    = 4'd1;
  localparam logic [7:0] HEADER_SKIP_RESET = 8'd54;

  typedef struct packed {
    logic [63:0] pass_chars;
    logic [3:0]  pass_len;
    logic [7:0]  header_skip;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lse_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lse_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output lse_pkg::cfg_t    cfg
);

  // Register file with index decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pass_chars  <= '0;
      cfg.pass_len    <= lse_pkg::PASS_LEN_RESET;
      cfg.header_skip <= lse_pkg::HEADER_SKIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lse_pkg::REG_PASS_CHARS:  cfg.pass_chars  <= cfg_data;
        lse_pkg::REG_PASS_LEN:    cfg.pass_len    <= cfg_data[3:0];
        lse_pkg::REG_HEADER_SKIP: cfg.header_skip <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lse_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lse_core #(
  parameter int MAX_PASS_CHARS = 8,
  parameter int SIZE_WORD_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       data_bit,
  input  wire lse_pkg::cfg_t cfg,
  output logic            res_valid,
  output lse_pkg::result_t res
);

  localparam int BitCntW = $clog2(SIZE_WORD_BITS);
  localparam logic [BitCntW-1:0] CharLast = BitCntW'(7);
  localparam logic [BitCntW-1:0] WordLast = BitCntW'(SIZE_WORD_BITS - 1);
  localparam logic [3:0] MaxLen = 4'(MAX_PASS_CHARS);

  lse_pkg::phase_t           phase, phase_next;
  logic [7:0]                header_count, header_count_next;
  logic [BitCntW-1:0]        bit_count, bit_count_next;
  logic [SIZE_WORD_BITS-1:0] shift_word, shift_word_next;
  logic [SIZE_WORD_BITS-1:0] item_count, item_count_next;
  logic [2:0]                pass_index, pass_index_next;
  logic                      mismatch_seen, mismatch_seen_next;

  logic [SIZE_WORD_BITS-1:0] shifted;
  logic [SIZE_WORD_BITS-1:0] item_dec;
  logic                      char_done, word_done;
  logic [7:0]                expect_char;
  logic                      mismatch_now;
  logic [3:0]                eff_len;
  logic                      pass_last;

  // Shared datapath terms
  assign shifted      = {shift_word[SIZE_WORD_BITS-2:0], data_bit};
  assign item_dec     = item_count - 1'b1;
  assign char_done    = (bit_count == CharLast);
  assign word_done    = (bit_count == WordLast);
  assign expect_char  = cfg.pass_chars[{pass_index, 3'b000} +: 8];
  assign mismatch_now = mismatch_seen | (shifted[7:0] != expect_char);

  // Passcode length clamped to 1..MAX_PASS_CHARS
  always_comb begin
    priority if (cfg.pass_len == 4'd0) eff_len = 4'd1;
    else if (cfg.pass_len > MaxLen)    eff_len = MaxLen;
    else                               eff_len = cfg.pass_len;
  end
  assign pass_last = (({1'b0, pass_index} + 4'd1) >= eff_len);

  // Per-byte decode step
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    bit_count_next     = bit_count;
    shift_word_next    = shift_word;
    item_count_next    = item_count;
    pass_index_next    = pass_index;
    mismatch_seen_next = mismatch_seen;
    res_valid          = 1'b0;
    res.data           = 8'd0;
    res.kind           = lse_pkg::KIND_EXT;
    res.last           = 1'b0;

    priority if (!accept) begin
    end else if (phase == lse_pkg::PH_HEADER && header_count < cfg.header_skip) begin
      header_count_next = header_count + 8'd1;
    end else if (phase == lse_pkg::PH_HEADER || phase == lse_pkg::PH_PASS) begin
      // header done: this byte already carries the first passcode bit
      phase_next = lse_pkg::PH_PASS;
      if (char_done) begin
        bit_count_next     = '0;
        shift_word_next    = '0;
        mismatch_seen_next = mismatch_now;
        if (pass_last) begin
          res_valid = 1'b1;
          if (mismatch_now) begin
            phase_next = lse_pkg::PH_STOP;
            res.kind   = lse_pkg::KIND_REJECT;
            res.last   = 1'b1;
          end else begin
            phase_next = lse_pkg::PH_EXT_LEN;
            res.kind   = lse_pkg::KIND_OK;
          end
        end else begin
          pass_index_next = pass_index + 3'd1;
        end
      end else begin
        bit_count_next  = bit_count + 1'b1;
        shift_word_next = shifted;
      end
    end else begin
      unique case (phase)
        lse_pkg::PH_EXT_LEN: begin
          if (word_done) begin
            bit_count_next  = '0;
            shift_word_next = '0;
            item_count_next = shifted;
            phase_next      = (shifted == '0) ? lse_pkg::PH_SIZE : lse_pkg::PH_EXT;
          end else begin
            bit_count_next  = bit_count + 1'b1;
            shift_word_next = shifted;
          end
        end
        lse_pkg::PH_EXT: begin
          if (char_done) begin
            bit_count_next  = '0;
            shift_word_next = '0;
            item_count_next = item_dec;
            if (item_dec == '0) phase_next = lse_pkg::PH_SIZE;
            res_valid = 1'b1;
            res.data  = shifted[7:0];
            res.kind  = lse_pkg::KIND_EXT;
          end else begin
            bit_count_next  = bit_count + 1'b1;
            shift_word_next = shifted;
          end
        end
        lse_pkg::PH_SIZE: begin
          if (word_done) begin
            bit_count_next  = '0;
            shift_word_next = '0;
            item_count_next = shifted;
            if (shifted == '0) begin
              phase_next = lse_pkg::PH_STOP;
              res_valid  = 1'b1;
              res.kind   = lse_pkg::KIND_EMPTY;
              res.last   = 1'b1;
            end else begin
              phase_next = lse_pkg::PH_DATA;
            end
          end else begin
            bit_count_next  = bit_count + 1'b1;
            shift_word_next = shifted;
          end
        end
        lse_pkg::PH_DATA: begin
          if (char_done) begin
            bit_count_next  = '0;
            shift_word_next = '0;
            item_count_next = item_dec;
            res_valid = 1'b1;
            res.data  = shifted[7:0];
            res.kind  = lse_pkg::KIND_DATA;
            if (item_dec == '0) begin
              phase_next = lse_pkg::PH_STOP;
              res.last   = 1'b1;
            end
          end else begin
            bit_count_next  = bit_count + 1'b1;
            shift_word_next = shifted;
          end
        end
        default: ;  // stopped: input is dropped
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lse_pkg::PH_HEADER;
      header_count  <= '0;
      bit_count     <= '0;
      shift_word    <= '0;
      item_count    <= '0;
      pass_index    <= '0;
      mismatch_seen <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      bit_count     <= bit_count_next;
      shift_word    <= shift_word_next;
      item_count    <= item_count_next;
      pass_index    <= pass_index_next;
      mismatch_seen <= mismatch_seen_next;
    end
  end

`ifndef SYNTHESIS
  // Nothing comes out once the stream is finished or rejected
  a_stop_silent: assert property (@(posedge clk) disable iff (rst)
    phase == lse_pkg::PH_STOP |-> !res_valid)
    else $error("result produced after stop");

  // A finishing result always parks the decoder
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |=> phase == lse_pkg::PH_STOP)
    else $error("last result without stop");

  // Accept verdict moves on to the extension length
  a_ok_next: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == lse_pkg::KIND_OK |=> phase == lse_pkg::PH_EXT_LEN)
    else $error("accept verdict without extension length phase");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lse_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lse_out_buf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lse_pkg::result_t push_res,
  input  wire logic          out_stall,
  output logic               out_valid,
  output lse_pkg::result_t   out_res,
  output logic               full
);

  logic             skid_valid;
  lse_pkg::result_t skid_res;
  logic             pop;

  assign pop  = out_valid & ~out_stall;
  assign full = skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || pop) out_valid  <= 1'b1;
      else                   skid_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: output register and skid slot
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_res <= skid_res;
    end else if (push) begin
      if (!out_valid || pop) out_res  <= push_res;
      else                   skid_res <= push_res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lsb_stego_extractor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// LSB stego extractor.
// Input channel: one image byte per request (in_valid / in_stall / image_byte).
// The first header_skip bytes are dropped; afterwards bit 0 of each byte is a
// hidden bit, gathered MSB first into passcode characters, a length word,
// extension characters, a size word and secret data bytes.
// Output channel: out_valid / out_stall with out_byte, out_kind, is_last.
// Kinds: extension char, data byte, passcode accepted, rejected, empty secret.
// A result is registered into the output register, or into the skid slot when
// the output is stalled. Throughput: one image byte per cycle while in_stall
// is low; the decode step is one pass through the bit shifter and counters
// between the input and the output register. A stalled result sits in the
// output register; one more result goes to a skid slot, and in_stall is
// raised while that slot is occupied. After a reject, an empty secret or the
// last data byte, input is taken and dropped until reset. Reset (rst,
// synchronous): decoder back to header skip, registers to their defaults
// (passcode_length 1, header_skip 54), output channel emptied. The user must
// write registers via cfg_we/cfg_index/cfg_data only while idle; unenforced.
module lsb_stego_extractor_top #(
  parameter int MAX_PASS_CHARS = 8,
  parameter int SIZE_WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  image_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_kind,
  output logic             is_last
);

  lse_pkg::cfg_t    cfg;
  lse_pkg::result_t core_res;
  lse_pkg::result_t out_res;
  logic             core_valid;
  logic             accept;
  logic             buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  lse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lse_core #(
    .MAX_PASS_CHARS (MAX_PASS_CHARS),
    .SIZE_WORD_BITS (SIZE_WORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_bit  (image_byte[0]),
    .cfg       (cfg),
    .res_valid (core_valid),
    .res       (core_res)
  );

  lse_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (core_valid),
    .push_res  (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign out_byte = out_res.data;
  assign out_kind = out_res.kind;
  assign is_last  = out_res.last;

endmodule

`default_nettype wire
